FILE: hw/rtl/drfd_pkg.sv
// shared constants, types and codes of the display return frame decoder
`timescale 1ns / 1ps
`default_nettype none
package drfd_pkg;

  // frame limits
  localparam int unsigned HDR_DEPTH       = 6;
  localparam int unsigned HDR_IDX_W       = $clog2(HDR_DEPTH);
  localparam logic [7:0]  MAX_FRAME_BYTES = 8'd255;
  localparam logic [7:0]  TERM_OVERHEAD   = 8'd4;
  localparam logic [1:0]  FF_RUN_LAST     = 2'd2;

  // byte codes
  localparam logic [7:0] BYTE_TERM   = 8'hFF;
  localparam logic [7:0] OP_TOUCH    = 8'h65;
  localparam logic [7:0] OP_PAGE     = 8'h66;
  localparam logic [7:0] OP_XY       = 8'h67;
  localparam logic [7:0] OP_STRING   = 8'h70;
  localparam logic [7:0] OP_INT      = 8'h71;
  localparam logic [7:0] CHR_C       = 8'h63;
  localparam logic [7:0] CHR_O       = 8'h6f;
  localparam logic [7:0] CHR_M       = 8'h6d;
  localparam logic [7:0] CHR_K       = 8'h6b;
  localparam logic [7:0] EVT_PRESS   = 8'h01;
  localparam logic [7:0] EVT_RELEASE = 8'h00;

  // frame kinds
  localparam logic [3:0] KIND_UNKNOWN     = 4'd0;
  localparam logic [3:0] KIND_PRESS       = 4'd1;
  localparam logic [3:0] KIND_RELEASE     = 4'd2;
  localparam logic [3:0] KIND_TOUCH_OTHER = 4'd3;
  localparam logic [3:0] KIND_PAGE_CHG    = 4'd4;
  localparam logic [3:0] KIND_PAGE_SAME   = 4'd5;
  localparam logic [3:0] KIND_XY_PRESS    = 4'd6;
  localparam logic [3:0] KIND_XY_RELEASE  = 4'd7;
  localparam logic [3:0] KIND_XY_OTHER    = 4'd8;
  localparam logic [3:0] KIND_STRING      = 4'd9;
  localparam logic [3:0] KIND_INTEGER     = 4'd10;
  localparam logic [3:0] KIND_COMOK       = 4'd11;

  typedef logic [HDR_DEPTH-1:0][7:0] hdr_arr_t;

  // frame view after the current byte is taken in
  typedef struct packed {
    hdr_arr_t   hdr;
    logic [7:0] count;
    logic       done;
  } frame_t;

  // one decoded result
  typedef struct packed {
    logic [3:0]  frame_kind;
    logic [7:0]  page;
    logic [7:0]  component;
    logic [15:0] x_coord;
    logic [15:0] y_coord;
    logic [31:0] int_value;
    logic [31:0] duration_ms;
    logic [7:0]  payload_length;
  } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/drfd_intf.sv
// handshake channel interfaces of the display return frame decoder
`timescale 1ns / 1ps
`default_nettype none

// received byte channel
interface drfd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] now_ms;
  modport source (output valid, output rx_byte, output now_ms, input ready);
  modport sink   (input valid, input rx_byte, input now_ms, output ready);
endinterface

// decoded result channel
interface drfd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  frame_kind;
  logic [7:0]  page;
  logic [7:0]  component;
  logic [15:0] x_coord;
  logic [15:0] y_coord;
  logic [31:0] int_value;
  logic [31:0] duration_ms;
  logic [7:0]  payload_length;
  modport source (output valid, output frame_kind, output page, output component,
                  output x_coord, output y_coord, output int_value,
                  output duration_ms, output payload_length, input ready);
  modport sink   (input valid, input frame_kind, input page, input component,
                  input x_coord, input y_coord, input int_value,
                  input duration_ms, input payload_length, output ready);
endinterface

// configuration write channel
interface drfd_cfg_if;
  logic valid;
  logic ready;
  logic report_page_zero;
  modport source (output valid, output report_page_zero, input ready);
  modport sink   (input valid, input report_page_zero, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/drfd_frame_track.sv
// frame tracker: header bytes, saturating byte count and 0xff run counter
`timescale 1ns / 1ps
`default_nettype none
module drfd_frame_track
  import drfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  output frame_t          frame
);

  hdr_arr_t   hdr_r, hdr_nxt;
  logic [7:0] count_r, count_nxt, count_inc;
  logic [1:0] ff_run_r, ff_run_nxt;
  logic       done;

  // header with the current byte written in place
  always_comb begin
    hdr_nxt = hdr_r;
    for (int i = 0; i < HDR_DEPTH; i++) begin
      if (count_r == 8'(i)) begin
        hdr_nxt[i] = rx_byte;
      end
    end
  end

  // saturating count and terminator detection
  assign count_inc = (count_r < MAX_FRAME_BYTES) ? count_r + 8'd1 : count_r;
  assign done      = (rx_byte == BYTE_TERM) && (ff_run_r >= FF_RUN_LAST);

  always_comb begin
    if (rx_byte != BYTE_TERM || done) begin
      ff_run_nxt = 2'd0;
    end else begin
      ff_run_nxt = ff_run_r + 2'd1;
    end
    count_nxt = done ? 8'd0 : count_inc;
  end

  assign frame.hdr   = hdr_nxt;
  assign frame.count = count_inc;
  assign frame.done  = done;

  // state update per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r    <= '0;
      count_r  <= '0;
      ff_run_r <= '0;
    end else if (step) begin
      hdr_r    <= hdr_nxt;
      count_r  <= count_nxt;
      ff_run_r <= ff_run_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/drfd_decode.sv
// frame decoder: kind selection, field extraction, page and press time state
`timescale 1ns / 1ps
`default_nettype none
module drfd_decode
  import drfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        commit,
  input  wire frame_t      frame,
  input  wire logic [31:0] now_ms,
  input  wire logic        report_page_zero,
  output result_t          res
);

  logic [7:0]  cur_page_r, cur_page_nxt;
  logic [31:0] press_time_r, press_time_nxt;
  hdr_arr_t    h;

  assign h = frame.hdr;

  // decode of the completed frame
  always_comb begin
    res                = '0;
    cur_page_nxt       = cur_page_r;
    press_time_nxt     = press_time_r;
    res.frame_kind     = KIND_UNKNOWN;
    res.payload_length = (frame.count >= TERM_OVERHEAD) ? frame.count - TERM_OVERHEAD
                                                        : 8'd0;
    unique case (h[0])
      OP_TOUCH: begin
        res.page      = h[1];
        res.component = h[2];
        if (h[3] == EVT_PRESS) begin
          press_time_nxt = now_ms;
          res.frame_kind = KIND_PRESS;
        end else if (h[3] == EVT_RELEASE) begin
          res.duration_ms = now_ms - press_time_r;
          res.frame_kind  = KIND_RELEASE;
        end else begin
          res.frame_kind = KIND_TOUCH_OTHER;
        end
      end
      OP_PAGE: begin
        res.page = h[1];
        if (h[1] != cur_page_r && (h[1] != 8'd0 || report_page_zero)) begin
          cur_page_nxt   = h[1];
          res.frame_kind = KIND_PAGE_CHG;
        end else begin
          res.frame_kind = KIND_PAGE_SAME;
        end
      end
      OP_XY: begin
        res.x_coord = {h[1], h[2]};
        res.y_coord = {h[3], h[4]};
        if (h[5] == EVT_PRESS) begin
          res.frame_kind = KIND_XY_PRESS;
        end else if (h[5] == EVT_RELEASE) begin
          res.frame_kind = KIND_XY_RELEASE;
        end else begin
          res.frame_kind = KIND_XY_OTHER;
        end
      end
      OP_STRING: begin
        res.frame_kind = KIND_STRING;
      end
      OP_INT: begin
        res.int_value  = {h[4], h[3], h[2], h[1]};
        res.frame_kind = KIND_INTEGER;
      end
      CHR_C: begin
        if (h[1] == CHR_O && h[2] == CHR_M && h[3] == CHR_O && h[4] == CHR_K) begin
          res.frame_kind = KIND_COMOK;
        end
      end
      default: begin
        res.frame_kind = KIND_UNKNOWN;
      end
    endcase
  end

  // page and press time kept across frames
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_page_r   <= '0;
      press_time_r <= '0;
    end else if (commit) begin
      cur_page_r   <= cur_page_nxt;
      press_time_r <= press_time_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/display_return_frame_decoder.sv
// top level: input register, frame tracker, decoder and result register
// a terminating byte is captured in the input register; its decoded result is loaded into
//   the result register when that byte leaves the input register
// throughput: one byte per cycle; the result register is refilled while held
//   results drain, the only stall is a finished frame meeting a full result register
// reset: synchronous active-low rst_n clears the frame state, page, press time,
//   report flag and both valid flags; no clearing pass, bytes are taken right away
`timescale 1ns / 1ps
`default_nettype none
module display_return_frame_decoder
  import drfd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  drfd_in_if.sink     in_ch,
  drfd_out_if.source  out_ch,
  drfd_cfg_if.sink    cfg_ch
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic [31:0] s1_now_r;
  logic        s1_fire;
  logic        out_valid_r;
  result_t     res_r, res_nxt;
  logic        rpz_r;
  frame_t      frame;

  // configuration register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpz_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      rpz_r <= cfg_ch.report_page_zero;
    end
  end

  // input register stage
  assign s1_fire     = s1_valid_r && (!frame.done || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.rx_byte;
      s1_now_r  <= in_ch.now_ms;
    end
  end

  drfd_frame_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_fire),
    .rx_byte (s1_byte_r),
    .frame   (frame)
  );

  drfd_decode u_decode (
    .clk              (clk),
    .rst_n            (rst_n),
    .commit           (s1_fire && frame.done),
    .frame            (frame),
    .now_ms           (s1_now_r),
    .report_page_zero (rpz_r),
    .res              (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && frame.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && frame.done) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.frame_kind     = res_r.frame_kind;
  assign out_ch.page           = res_r.page;
  assign out_ch.component      = res_r.component;
  assign out_ch.x_coord        = res_r.x_coord;
  assign out_ch.y_coord        = res_r.y_coord;
  assign out_ch.int_value      = res_r.int_value;
  assign out_ch.duration_ms    = res_r.duration_ms;
  assign out_ch.payload_length = res_r.payload_length;

  // checks
  a_done_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && frame.done |=> out_valid_r)
    else $error("finished frame did not load the result register");

  a_stall_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_byte_r))
    else $error("stalled byte lost from input register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && frame.done |-> !out_valid_r || out_ch.ready)
    else $error("result register overwritten while held");

  a_duration_only_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.frame_kind != KIND_RELEASE |-> res_r.duration_ms == 32'd0)
    else $error("duration given for a kind other than release");

endmodule
`default_nettype wire
